### hw/rtl/vector_glyph_stroke_transform_unit_defines.svh
`ifndef VECTOR_GLYPH_STROKE_TRANSFORM_UNIT_DEFINES_SVH
`define VECTOR_GLYPH_STROKE_TRANSFORM_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the trigger.
`define VGST_ASSERT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the trigger.
`define VGST_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/vgst_pkg.sv
`timescale 1ns / 1ps

package vgst_pkg;

   localparam int CoordW   = 8;
   localparam int ScaleW   = 12;
   localparam int TrigW    = 16;
   localparam int OrgW     = 16;
   localparam int SegW     = 17;
   localparam int ProdW    = CoordW + TrigW;
   localparam int SumW     = ProdW + 1;
   localparam int ScProdW  = CoordW + ScaleW + 1;
   localparam int ScFracW  = 8;
   localparam int RotFracW = 14;
   localparam int RotQW    = SumW - RotFracW;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   localparam int QDepth   = 2;
   localparam int QIdxW    = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCntW    = $clog2(QDepth + 1);

   localparam logic [CsrIdxW-1:0] CsrScale  = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrCos    = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrSin    = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrOrigX  = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrOrigY  = 3'd4;

   localparam logic [ScaleW-1:0]       ScaleReset = 12'd256;
   localparam logic signed [TrigW-1:0] CosReset   = 16'sd16384;
   localparam logic signed [TrigW-1:0] SinReset   = 16'sd0;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [SegW-1:0]   seg_coord_type;

   // Scaled start and end point of one segment, before rotation.
   typedef struct packed {
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
   } seg_pts_type;

   typedef struct packed {
      logic signed [TrigW-1:0] rot_cos;
      logic signed [TrigW-1:0] rot_sin;
      logic signed [OrgW-1:0]  org_x;
      logic signed [OrgW-1:0]  org_y;
   } rot_cfg_type;

   // Q4.8 scale, truncated toward zero, saturated to the coordinate range.
   function automatic coord_type scale_coord(input coord_type v,
                                             input logic [ScaleW-1:0] s);
      logic signed [ScProdW-1:0] p;
      logic signed [ScProdW-1:0] adj;
      logic signed [ScProdW-ScFracW-1:0] q;
      coord_type r;
      p   = ScProdW'(v) * signed'(ScProdW'(s));
      adj = p[ScProdW-1] ? p + ScProdW'((1 << ScFracW) - 1) : p;
      q   = adj[ScProdW-1:ScFracW];
      if (q > (ScProdW-ScFracW)'(127)) begin
         r = 8'sd127;
      end else if (q < -(ScProdW-ScFracW)'(128)) begin
         r = -8'sd128;
      end else begin
         r = q[CoordW-1:0];
      end
      return r;
   endfunction

   // Combines two Q1.14 products, adds one half, truncates toward zero and adds the origin.
   function automatic seg_coord_type rot_round(input logic signed [ProdW-1:0] a,
                                               input logic signed [ProdW-1:0] b,
                                               input logic sub,
                                               input logic signed [OrgW-1:0] org);
      logic signed [SumW-1:0] be;
      logic signed [SumW-1:0] s;
      logic signed [SumW-1:0] adj;
      logic signed [RotQW-1:0] q;
      be  = SumW'(b);
      s   = SumW'(a) + (sub ? -be : be) + SumW'(1 << (RotFracW - 1));
      adj = s[SumW-1] ? s + SumW'((1 << RotFracW) - 1) : s;
      q   = adj[SumW-1:RotFracW];
      return SegW'(q) + SegW'(org);
   endfunction

endpackage

### hw/rtl/vgst_req_if.sv
`timescale 1ns / 1ps

interface vgst_req_if;
   logic                 valid;
   logic                 ready;
   vgst_pkg::coord_type  vertex_x;
   vgst_pkg::coord_type  vertex_y;
   logic                 pen_lift;
   logic                 glyph_start;

   modport source (output valid, output vertex_x, output vertex_y,
                   output pen_lift, output glyph_start, input ready);
   modport sink   (input valid, input vertex_x, input vertex_y,
                   input pen_lift, input glyph_start, output ready);
endinterface

### hw/rtl/vgst_rsp_if.sv
`timescale 1ns / 1ps

interface vgst_rsp_if;
   logic                    valid;
   logic                    ready;
   vgst_pkg::seg_coord_type seg_x0;
   vgst_pkg::seg_coord_type seg_y0;
   vgst_pkg::seg_coord_type seg_x1;
   vgst_pkg::seg_coord_type seg_y1;

   modport source (output valid, output seg_x0, output seg_y0,
                   output seg_x1, output seg_y1, input ready);
   modport sink   (input valid, input seg_x0, input seg_y0,
                   input seg_x1, input seg_y1, output ready);
endinterface

### hw/rtl/vgst_front.sv
`timescale 1ns / 1ps

module vgst_front (
   input  logic                         clock,
   input  logic                         reset,
   vgst_req_if.sink                     req_ch,
   input  logic [vgst_pkg::ScaleW-1:0]  scale,
   output logic                         push_valid,
   input  logic                         push_ready,
   output vgst_pkg::seg_pts_type        push_data
);

   vgst_pkg::coord_type cur_x_ff, cur_x_in;
   vgst_pkg::coord_type cur_y_ff, cur_y_in;
   logic                pen_on_ff, pen_on_in;
   vgst_pkg::coord_type nx, ny;
   logic                accept;

   // A request is taken only while the queue has room, even if it yields no segment.
   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;

   assign nx = vgst_pkg::scale_coord(req_ch.vertex_x, scale);
   assign ny = vgst_pkg::scale_coord(req_ch.vertex_y, scale);

   assign push_data.x0 = cur_x_ff;
   assign push_data.y0 = cur_y_ff;
   assign push_data.x1 = nx;
   assign push_data.y1 = ny;

   always_comb begin
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      pen_on_in   = pen_on_ff;
      push_valid  = 1'b0;
      if (accept) begin
         priority if (req_ch.glyph_start) begin
            cur_x_in    = nx;
            cur_y_in    = ny;
            pen_on_in   = 1'b1;
         end else if (req_ch.pen_lift) begin
            pen_on_in   = 1'b0;
         end else begin
            cur_x_in    = nx;
            cur_y_in    = ny;
            pen_on_in   = 1'b1;
            push_valid  = pen_on_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
         pen_on_ff   <= 1'b1;
      end else begin
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         pen_on_ff   <= pen_on_in;
      end
   end

endmodule

### hw/rtl/vgst_queue.sv
`timescale 1ns / 1ps

`include "vector_glyph_stroke_transform_unit_defines.svh"

module vgst_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  vgst_pkg::seg_pts_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output vgst_pkg::seg_pts_type pop_data
);

   vgst_pkg::seg_pts_type             entries_ff [vgst_pkg::QDepth];
   logic [vgst_pkg::QIdxW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [vgst_pkg::QIdxW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [vgst_pkg::QCntW-1:0]        count_ff, count_in;
   logic                              do_push, do_pop;

   assign push_ready = (count_ff != vgst_pkg::QCntW'(vgst_pkg::QDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == vgst_pkg::QIdxW'(vgst_pkg::QDepth - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == vgst_pkg::QIdxW'(vgst_pkg::QDepth - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `VGST_ASSERT(a_count_bound, clock, reset, 1'b1, count_ff <= vgst_pkg::QCntW'(vgst_pkg::QDepth), "queue count exceeds depth")
   `VGST_ASSERT_NEXT(a_count_up, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "queue count did not grow on push")
   `VGST_ASSERT_NEXT(a_count_down, clock, reset, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1, "queue count did not shrink on pop")

endmodule

### hw/rtl/vgst_back.sv
`timescale 1ns / 1ps

`include "vector_glyph_stroke_transform_unit_defines.svh"

module vgst_back (
   input  logic                  clock,
   input  logic                  reset,
   input  vgst_pkg::rot_cfg_type cfg,
   input  logic                  head_valid,
   output logic                  head_pop,
   input  vgst_pkg::seg_pts_type head,
   vgst_rsp_if.source            rsp_ch
);

   typedef enum logic [2:0] {
      S_LOAD = 3'b001,
      S_MID  = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic signed [vgst_pkg::ProdW-1:0] prod_xc_ff, prod_ys_ff, prod_xs_ff, prod_yc_ff;
   vgst_pkg::seg_coord_type           r0x_ff, r0x_in, r0y_ff, r0y_in;
   vgst_pkg::seg_coord_type           res_x, res_y;
   vgst_pkg::seg_coord_type           o_x0_ff, o_y0_ff, o_x1_ff, o_y1_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              out_load, prod_load, sel_end, out_free;
   vgst_pkg::coord_type               pt_x, pt_y;

   // The four multipliers serve the start point first and the end point in the cycle after.
   assign sel_end  = (state_ff == S_MID);
   assign pt_x     = sel_end ? head.x1 : head.x0;
   assign pt_y     = sel_end ? head.y1 : head.y0;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign res_x = vgst_pkg::rot_round(prod_xc_ff, prod_ys_ff, 1'b1, cfg.org_x);
   assign res_y = vgst_pkg::rot_round(prod_xs_ff, prod_yc_ff, 1'b0, cfg.org_y);

   always_comb begin
      state_in     = state_ff;
      r0x_in       = r0x_ff;
      r0y_in       = r0y_ff;
      prod_load    = 1'b0;
      head_pop     = 1'b0;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         S_LOAD: begin
            if (head_valid) begin
               prod_load = 1'b1;
               state_in  = S_MID;
            end
         end
         S_MID: begin
            r0x_in    = res_x;
            r0y_in    = res_y;
            prod_load = 1'b1;
            head_pop  = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (head_valid) begin
                  prod_load = 1'b1;
                  state_in  = S_MID;
               end else begin
                  state_in  = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r0x_ff <= r0x_in;
      r0y_ff <= r0y_in;
      if (prod_load) begin
         prod_xc_ff <= vgst_pkg::ProdW'(pt_x) * vgst_pkg::ProdW'(cfg.rot_cos);
         prod_ys_ff <= vgst_pkg::ProdW'(pt_y) * vgst_pkg::ProdW'(cfg.rot_sin);
         prod_xs_ff <= vgst_pkg::ProdW'(pt_x) * vgst_pkg::ProdW'(cfg.rot_sin);
         prod_yc_ff <= vgst_pkg::ProdW'(pt_y) * vgst_pkg::ProdW'(cfg.rot_cos);
      end
      if (out_load) begin
         o_x0_ff <= r0x_ff;
         o_y0_ff <= r0y_ff;
         o_x1_ff <= res_x;
         o_y1_ff <= res_y;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.seg_x0 = o_x0_ff;
   assign rsp_ch.seg_y0 = o_y0_ff;
   assign rsp_ch.seg_x1 = o_x1_ff;
   assign rsp_ch.seg_y1 = o_y1_ff;

   `VGST_ASSERT(a_mid_has_head, clock, reset, state_ff == S_MID, head_valid, "end point stage without a queued segment")
   `VGST_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_OUT), "response raised outside the output step")
   `VGST_ASSERT(a_pop_only_mid, clock, reset, head_pop, state_ff == S_MID, "queue popped outside the end point step")

endmodule

### hw/rtl/vector_glyph_stroke_transform_unit.sv
`timescale 1ns / 1ps

// Glyph stroke transform. Each request carries one glyph vertex; it is scaled
// by csr register 0 (Q4.8), rotated by registers 1 and 2 (Q1.14 cosine and
// sine) and moved by the origin in registers 3 and 4, and every vertex drawn
// with the pen down yields one line segment response. The front end takes one
// request per cycle while its two-entry segment queue has room; vertices that
// set a point or lift the pen need that room too but yield no segment. The
// back end shares four 8x16 multipliers between the start and end point of a
// segment, one point after the other, and starts on the next segment while it
// hands out the last. Write the registers only while no request is in flight.
module vector_glyph_stroke_transform_unit (
   input  logic                           clock,
   input  logic                           reset,
   vgst_req_if.sink                       req_ch,
   vgst_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [vgst_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [vgst_pkg::CsrDataW-1:0]  csr_wdata
);

   logic [vgst_pkg::ScaleW-1:0]       scale_ff;
   logic signed [vgst_pkg::TrigW-1:0] cos_ff, sin_ff;
   logic signed [vgst_pkg::OrgW-1:0]  org_x_ff, org_y_ff;
   vgst_pkg::rot_cfg_type             rot_cfg;

   logic                  push_valid, push_ready;
   vgst_pkg::seg_pts_type push_data;
   logic                  pop_valid, pop_ready;
   vgst_pkg::seg_pts_type pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= vgst_pkg::ScaleReset;
         cos_ff   <= vgst_pkg::CosReset;
         sin_ff   <= vgst_pkg::SinReset;
         org_x_ff <= '0;
         org_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            vgst_pkg::CsrScale: scale_ff <= csr_wdata[vgst_pkg::ScaleW-1:0];
            vgst_pkg::CsrCos:   cos_ff   <= signed'(csr_wdata[vgst_pkg::TrigW-1:0]);
            vgst_pkg::CsrSin:   sin_ff   <= signed'(csr_wdata[vgst_pkg::TrigW-1:0]);
            vgst_pkg::CsrOrigX: org_x_ff <= signed'(csr_wdata[vgst_pkg::OrgW-1:0]);
            vgst_pkg::CsrOrigY: org_y_ff <= signed'(csr_wdata[vgst_pkg::OrgW-1:0]);
            default: begin
            end
         endcase
      end
   end

   assign rot_cfg.rot_cos = cos_ff;
   assign rot_cfg.rot_sin = sin_ff;
   assign rot_cfg.org_x   = org_x_ff;
   assign rot_cfg.org_y   = org_y_ff;

   vgst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .scale      (scale_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   vgst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   vgst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (rot_cfg),
      .head_valid (pop_valid),
      .head_pop   (pop_ready),
      .head       (pop_data),
      .rsp_ch     (rsp_ch)
   );

endmodule

### verif/vgst_segment_checker.sv
`timescale 1ns / 1ps

module vgst_segment_checker (
   input  logic                           clock,
   input  logic                           reset,
   vgst_req_if                            req_mon,
   vgst_rsp_if                            rsp_mon,
   input  logic                           csr_we,
   input  logic [vgst_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [vgst_pkg::CsrDataW-1:0]  csr_wdata,
   output int                             error_count,
   output int                             pending_count,
   output int                             segments_checked
);

   typedef struct packed {
      vgst_pkg::seg_coord_type x0;
      vgst_pkg::seg_coord_type y0;
      vgst_pkg::seg_coord_type x1;
      vgst_pkg::seg_coord_type y1;
   } stroke_seg_type;

   stroke_seg_type predicted_segs[$];

   logic [vgst_pkg::ScaleW-1:0]       scale_cfg;
   logic signed [vgst_pkg::TrigW-1:0] cos_cfg;
   logic signed [vgst_pkg::TrigW-1:0] sin_cfg;
   logic signed [vgst_pkg::OrgW-1:0]  org_x_cfg;
   logic signed [vgst_pkg::OrgW-1:0]  org_y_cfg;

   // Last scaled point and pen state, as the block keeps them.
   vgst_pkg::coord_type cur_x;
   vgst_pkg::coord_type cur_y;
   logic                pen_on;

   function automatic vgst_pkg::coord_type scale_vertex(vgst_pkg::coord_type v);
      longint p;
      p = longint'(v) * longint'(scale_cfg) / 256;
      if (p > 127) begin
         p = 127;
      end else if (p < -128) begin
         p = -128;
      end
      return vgst_pkg::CoordW'(p);
   endfunction

   // Adds one half and divides, which truncates toward zero.
   function automatic longint q14_round(longint sum);
      return (sum + 8192) / 16384;
   endfunction

   task automatic predict_vertex(vgst_pkg::coord_type vx, vgst_pkg::coord_type vy,
                                 logic lift, logic start);
      vgst_pkg::coord_type nx;
      vgst_pkg::coord_type ny;
      longint              c;
      longint              s;
      stroke_seg_type      seg;
      nx = scale_vertex(vx);
      ny = scale_vertex(vy);
      c  = cos_cfg;
      s  = sin_cfg;
      if (start) begin
         cur_x  = nx;
         cur_y  = ny;
         pen_on = 1'b1;
      end else if (lift) begin
         pen_on = 1'b0;
      end else if (!pen_on) begin
         cur_x  = nx;
         cur_y  = ny;
         pen_on = 1'b1;
      end else begin
         seg.x0 = vgst_pkg::SegW'(q14_round(cur_x * c - cur_y * s) + longint'(org_x_cfg));
         seg.y0 = vgst_pkg::SegW'(q14_round(cur_x * s + cur_y * c) + longint'(org_y_cfg));
         seg.x1 = vgst_pkg::SegW'(q14_round(nx * c - ny * s) + longint'(org_x_cfg));
         seg.y1 = vgst_pkg::SegW'(q14_round(nx * s + ny * c) + longint'(org_y_cfg));
         predicted_segs.push_back(seg);
         cur_x = nx;
         cur_y = ny;
      end
   endtask

   task automatic check_segment();
      stroke_seg_type got;
      stroke_seg_type want;
      got.x0 = rsp_mon.seg_x0;
      got.y0 = rsp_mon.seg_y0;
      got.x1 = rsp_mon.seg_x1;
      got.y1 = rsp_mon.seg_y1;
      if (predicted_segs.size() == 0) begin
         error_count++;
         if (error_count <= 10) begin
            $display("%0t: segment (%0d,%0d)-(%0d,%0d) with no vertex to account for it",
                     $realtime, got.x0, got.y0, got.x1, got.y1);
         end
      end else begin
         want = predicted_segs.pop_front();
         segments_checked++;
         if (got !== want) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: segment mismatch: expected (%0d,%0d)-(%0d,%0d),",
                        $realtime, want.x0, want.y0, want.x1, want.y1);
               $display("   got (%0d,%0d)-(%0d,%0d)",
                        got.x0, got.y0, got.x1, got.y1);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scale_cfg        = vgst_pkg::ScaleReset;
         cos_cfg          = vgst_pkg::CosReset;
         sin_cfg          = vgst_pkg::SinReset;
         org_x_cfg        = '0;
         org_y_cfg        = '0;
         cur_x            = '0;
         cur_y            = '0;
         pen_on           = 1'b1;
         error_count      = 0;
         segments_checked = 0;
         predicted_segs.delete();
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               vgst_pkg::CsrScale: scale_cfg = csr_wdata[vgst_pkg::ScaleW-1:0];
               vgst_pkg::CsrCos:   cos_cfg   = csr_wdata;
               vgst_pkg::CsrSin:   sin_cfg   = csr_wdata;
               vgst_pkg::CsrOrigX: org_x_cfg = csr_wdata;
               vgst_pkg::CsrOrigY: org_y_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_segment();
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_vertex(req_mon.vertex_x, req_mon.vertex_y,
                           req_mon.pen_lift, req_mon.glyph_start);
         end
      end
      pending_count <= predicted_segs.size();
   end

endmodule

### verif/tb_vector_glyph_stroke_transform_unit.sv
`timescale 1ns / 1ps

module tb_vector_glyph_stroke_transform_unit;

   localparam int CycleLimit    = 200000;
   localparam int LongStall     = 150;
   localparam int SettleCycles  = 8;
   localparam int ItemsPerPhase = 175;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [vgst_pkg::CsrIdxW-1:0]  csr_index;
   logic [vgst_pkg::CsrDataW-1:0] csr_wdata;

   int error_count;
   int pending_count;
   int segments_checked;
   int vertices_sent    = 0;
   int settings_written = 0;
   int cycle_count      = 0;
   int send_idle_pct    = 0;
   int recv_idle_pct    = 0;
   int stall_requests   = 0;
   int stalls_served    = 0;
   int stall_left       = 0;

   vgst_req_if req_ch();
   vgst_rsp_if rsp_ch();

   vector_glyph_stroke_transform_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   vgst_segment_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .segments_checked (segments_checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("** vector_glyph_stroke_transform_unit: FAILED **");
         $finish;
      end
   end

   // Response side: random back-pressure, plus a long hold-off on request so
   // that the segment queue fills and the block stops taking requests.
   always @(posedge clock) begin
      if (stalls_served != stall_requests) begin
         stalls_served = stall_requests;
         stall_left    = LongStall;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic vgst_pkg::coord_type rand_coord();
      case ($urandom_range(7))
         0:       return 8'sh80;
         1:       return 8'sh7F;
         2:       return 8'sh81;
         default: return vgst_pkg::CoordW'($urandom);
      endcase
   endfunction

   task automatic send_vertex(vgst_pkg::coord_type vx, vgst_pkg::coord_type vy,
                              logic lift, logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.vertex_x    <= vx;
      req_ch.vertex_y    <= vy;
      req_ch.pen_lift    <= lift;
      req_ch.glyph_start <= start;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      vertices_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_settings(logic [vgst_pkg::ScaleW-1:0] scale,
                                 logic [vgst_pkg::TrigW-1:0] c,
                                 logic [vgst_pkg::TrigW-1:0] s,
                                 logic [vgst_pkg::OrgW-1:0] ox,
                                 logic [vgst_pkg::OrgW-1:0] oy);
      csr_we    <= 1'b1;
      csr_index <= vgst_pkg::CsrScale;
      csr_wdata <= vgst_pkg::CsrDataW'(scale);
      @(posedge clock);
      csr_index <= vgst_pkg::CsrCos;
      csr_wdata <= c;
      @(posedge clock);
      csr_index <= vgst_pkg::CsrSin;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= vgst_pkg::CsrOrigX;
      csr_wdata <= ox;
      @(posedge clock);
      csr_index <= vgst_pkg::CsrOrigY;
      csr_wdata <= oy;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_written++;
   endtask

   // Mostly whole glyphs: a start vertex, then strokes separated by pen lifts.
   // The rest is raw requests with arbitrary flags.
   task automatic run_glyphs(int count);
      int sent;
      int strokes;
      int verts;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 80) begin
            send_vertex(rand_coord(), rand_coord(), 1'b0, 1'b1);
            sent++;
            strokes = $urandom_range(1, 4);
            for (int k = 0; k < strokes; k++) begin
               if (k > 0) begin
                  send_vertex(rand_coord(), rand_coord(), 1'b1, 1'b0);
                  sent++;
               end
               verts = $urandom_range(1, 6);
               repeat (verts) begin
                  send_vertex(rand_coord(), rand_coord(), 1'b0, 1'b0);
                  sent++;
               end
            end
         end else begin
            send_vertex(vgst_pkg::CoordW'($urandom), vgst_pkg::CoordW'($urandom),
                        1'($urandom), 1'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.vertex_x    <= '0;
      req_ch.vertex_y    <= '0;
      req_ch.pen_lift    <= 1'b0;
      req_ch.glyph_start <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= vgst_pkg::CsrScale;
      csr_wdata          <= '0;
      send_idle_pct      <= 26;
      recv_idle_pct      <= 64;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset settings. The first vertex has no
      // glyph start ahead of it, so it draws from the origin.
      send_vertex(8'sd5, -8'sd7, 1'b0, 1'b0);
      send_vertex(8'sh7F, 8'sh7F, 1'b0, 1'b0);
      send_vertex(8'sh80, 8'sh80, 1'b0, 1'b0);
      send_vertex(8'sh81, 8'sh7F, 1'b0, 1'b0);
      send_vertex(8'sd100, -8'sd100, 1'b1, 1'b0);
      send_vertex(8'sd3, 8'sd4, 1'b0, 1'b0);
      send_vertex(-8'sd5, 8'sd6, 1'b0, 1'b0);
      send_vertex(8'sd10, 8'sd10, 1'b0, 1'b1);
      send_vertex(-8'sd20, 8'sd30, 1'b1, 1'b1);
      send_vertex(8'sd0, 8'sd0, 1'b0, 1'b0);
      send_vertex(8'sh7F, 8'sh80, 1'b1, 1'b0);
      send_vertex(8'sh80, 8'sh7F, 1'b1, 1'b0);
      send_vertex(-8'sd1, -8'sd1, 1'b0, 1'b0);
      send_vertex(8'sd0, 8'sd0, 1'b1, 1'b0);
      send_vertex(8'sd7, 8'sd7, 1'b0, 1'b1);
      send_vertex(8'sh80, 8'sh7F, 1'b0, 1'b0);
      send_vertex(8'sh7F, 8'sh80, 1'b0, 1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         case (ph)
            0: write_settings(12'd256, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
            1: write_settings(12'd4095, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
            2: write_settings(12'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
            3: write_settings(12'd384, 16'sd11585, 16'sd11585, 16'sd100, -16'sd200);
            4: write_settings(vgst_pkg::ScaleW'($urandom), vgst_pkg::TrigW'($urandom),
                              vgst_pkg::TrigW'($urandom), vgst_pkg::OrgW'($urandom),
                              vgst_pkg::OrgW'($urandom));
            default: write_settings(12'd4095, -16'sd16384, 16'sd16384, 16'sh7FFF,
                                    16'sh8000);
         endcase
         if (ph < 2) begin
            send_idle_pct <= 26;
            recv_idle_pct <= 64;
         end else if (ph < 4) begin
            send_idle_pct <= 64;
            recv_idle_pct <= 26;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         if (ph == 1 || ph == 4) begin
            stall_requests <= stall_requests + 1;
         end
         run_glyphs(ItemsPerPhase);
      end

      wait_idle();
      $display("Covered %0d vertex requests and %0d checked segments over %0d register settings,",
               vertices_sent, segments_checked, settings_written);
      $display("with random back-pressure on both sides and %0d-cycle response hold-offs.",
               LongStall);
      if (error_count == 0 && pending_count == 0) begin
         $display("** vector_glyph_stroke_transform_unit: PASSED **");
      end else begin
         $display("** vector_glyph_stroke_transform_unit: FAILED **");
      end
      $finish;
   end

endmodule
